// ----- hdl/x87r_pkg.sv -----
// Shared types and constants for the x87 extended-precision rounding core.
// No dependencies; used by the core and by its port checker.
`default_nettype none

package x87r_pkg;

	// Exponent arithmetic: signed, one bit wider than the input for the carry
	typedef logic signed [16:0] exp_t;

	localparam exp_t EXP_TINY        = -17'sd16383;
	localparam exp_t EXP_DENORM      = -17'sd16382;
	localparam exp_t EXP_LIMIT       = 17'sd16384;
	localparam exp_t EXP_BIAS        = 17'sd16383;
	localparam exp_t UNMASKED_ADJUST = 17'(3 * (1 << 13));
	localparam logic [14:0] EXP_SAT  = 15'h7fff;

	// Largest shift that still keeps bits of the significand
	localparam logic [14:0] SHIFT_MAX = 15'd64;

	// Rounding masks and units for each precision
	localparam logic [63:0] TOP_BIT  = 64'h8000_0000_0000_0000;
	localparam logic [63:0] KEEP_53  = 64'hffff_ffff_ffff_f800;
	localparam logic [63:0] UNIT_53  = 64'h0000_0000_0000_0800;
	localparam logic [63:0] KEEP_24  = 64'hffff_ff00_0000_0000;
	localparam logic [63:0] UNIT_24  = 64'h0000_0100_0000_0000;
	localparam logic [63:0] KEEP_64  = 64'hffff_ffff_ffff_ffff;
	localparam logic [63:0] UNIT_64  = 64'h0000_0000_0000_0001;
	localparam logic [10:0] HALF_53  = 11'h400;
	localparam logic [7:0]  HALF_24  = 8'h80;
	localparam logic [31:0] HALF_EXT = 32'h8000_0000;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_PRECISION = 2'd0,
		CFG_ROUNDING  = 2'd1,
		CFG_UFL_MASK  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PC_24   = 2'd0,
		PC_RSVD = 2'd1,
		PC_53   = 2'd2,
		PC_64   = 2'd3
	} prec_t;

	typedef enum logic [1:0] {
		RND_NEAREST = 2'd0,
		RND_DOWN    = 2'd1,
		RND_UP      = 2'd2,
		RND_CHOP    = 2'd3
	} rnd_t;

	typedef enum logic [1:0] {
		DN_NONE     = 2'd0,
		DN_MASKED   = 2'd1,
		DN_UNMASKED = 2'd2
	} denorm_t;

	typedef enum logic [1:0] {
		LOST_NONE = 2'd0,
		LOST_DN   = 2'd1,
		LOST_UP   = 2'd2
	} lost_t;

	typedef enum logic [1:0] {
		TAG_NORMAL   = 2'd0,
		TAG_NIL      = 2'd1,
		TAG_DENORMAL = 2'd2
	} tag_t;

	// Item after denormalisation
	typedef struct packed {
		logic [63:0] sig;
		logic [31:0] ext;
		exp_t        exp;
		logic        neg;
		denorm_t     denorm;
	} s1_t;

	// Item after rounding
	typedef struct packed {
		logic [63:0] sig;
		exp_t        exp;
		logic        neg;
		denorm_t     denorm;
		lost_t       lost;
	} s2_t;

endpackage

`default_nettype wire

// ----- hdl/x87_extended_round_core.sv -----
// x87 extended-precision rounding core: denormalise, round, finish flags.
// Depends on x87r_pkg (types, masks, codes).
`default_nettype none

//  channel   | handshake                        | payload
//  ----------+----------------------------------+--------------------------------------
//  operand   | operand_valid / operand_stall    | significand_in, extension_in,
//            |                                  | exponent_in, sign_in
//  result    | result_valid / result_stall      | significand_out, exponent_out, sign_out,
//            |                                  | result_tag, rounded_up/down, flags
//  config    | cfg_we, cfg_index, cfg_data      | precision, rounding mode, ufl mask
//
// Three register stages (denormalise, round, flags/output), one item per cycle
// sustained while result_stall is low. The 64-bit rounding add sets the middle stage.
// A stage advances whenever the stage after it is empty or moving, so bubbles
// close up behind a stalled result; operand_stall rises only when all stages
// hold items and result_stall is high. Reset clears valid bits and loads the
// configuration reset values; there is no clearing pass.

module x87_extended_round_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        operand_valid,
	output logic             operand_stall,
	input  wire logic [63:0] significand_in,
	input  wire logic [31:0] extension_in,
	input  wire logic [15:0] exponent_in,
	input  wire logic        sign_in,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [63:0]      significand_out,
	output logic [14:0]      exponent_out,
	output logic             sign_out,
	output logic [1:0]       result_tag,
	output logic             rounded_up,
	output logic             rounded_down,
	output logic             underflow_flag,
	output logic             overflow_flag,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [1:0]  cfg_data
);

	x87r_pkg::prec_t prec_q;
	x87r_pkg::rnd_t  rnd_q;
	logic            ufl_mask_q;

	logic v1_s1, v2_s2, v3_s3;
	logic adv1, adv2, adv3;

	x87r_pkg::s1_t s1_d, item_s1;
	x87r_pkg::s2_t s2_d, item_s2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prec_q     <= x87r_pkg::PC_64;
			rnd_q      <= x87r_pkg::RND_NEAREST;
			ufl_mask_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (x87r_pkg::cfg_idx_t'(cfg_index))
				x87r_pkg::CFG_PRECISION: prec_q     <= x87r_pkg::prec_t'(cfg_data);
				x87r_pkg::CFG_ROUNDING:  rnd_q      <= x87r_pkg::rnd_t'(cfg_data);
				x87r_pkg::CFG_UFL_MASK:  ufl_mask_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Advance a stage when the next one is empty or moving on
	assign adv3          = !v3_s3 || !result_stall;
	assign adv2          = !v2_s2 || adv3;
	assign adv1          = !v1_s1 || adv2;
	assign operand_stall = !adv1;

	// Stage 1: denormalise tiny values with a sticky extension
	x87r_pkg::exp_t e_in;
	x87r_pkg::exp_t shift_full;
	logic [14:0]    shift_amt;
	logic [95:0]    wide_shifted;
	logic           tiny;
	logic           sticky;

	always_comb begin
		e_in         = x87r_pkg::exp_t'($signed(exponent_in));
		tiny         = e_in <= x87r_pkg::EXP_TINY;
		shift_full   = x87r_pkg::EXP_DENORM - e_in;
		shift_amt    = shift_full[14:0];
		wide_shifted = {significand_in, extension_in} >> shift_amt[6:0];
		// wide shifts fold the extension and only the low significand word into the sticky bit
		sticky       = (shift_amt > 15'd32) ? ((extension_in | significand_in[31:0]) != '0)
		                                    : (extension_in != '0);

		s1_d.sig    = significand_in;
		s1_d.ext    = extension_in;
		s1_d.exp    = e_in;
		s1_d.neg    = sign_in;
		s1_d.denorm = x87r_pkg::DN_NONE;
		if (tiny) begin
			if (ufl_mask_q) begin
				s1_d.denorm = x87r_pkg::DN_MASKED;
				s1_d.exp    = x87r_pkg::EXP_DENORM;
				if (shift_amt > x87r_pkg::SHIFT_MAX) begin
					s1_d.sig = '0;
					s1_d.ext = 32'd1;
				end else begin
					s1_d.sig = wide_shifted[95:32];
					s1_d.ext = wide_shifted[31:0] | {31'd0, sticky};
				end
			end else begin
				s1_d.denorm = x87r_pkg::DN_UNMASKED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (adv1) begin
			v1_s1 <= operand_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && operand_valid) begin
			item_s1 <= s1_d;
		end
	end

	// Stage 2: round to the selected precision
	logic [63:0] keep_mask, unit;
	logic        lost_any, above_half, at_half, lsb_odd, want_up;
	logic [64:0] sum;

	always_comb begin
		case (prec_q)
			x87r_pkg::PC_53: begin
				lost_any   = (item_s1.ext != '0) || (item_s1.sig[10:0] != '0);
				above_half = (item_s1.sig[10:0] > x87r_pkg::HALF_53) ||
				             ((item_s1.sig[10:0] == x87r_pkg::HALF_53) && (item_s1.ext != '0));
				at_half    = (item_s1.sig[10:0] == x87r_pkg::HALF_53) && (item_s1.ext == '0);
				lsb_odd    = item_s1.sig[11];
				keep_mask  = x87r_pkg::KEEP_53;
				unit       = x87r_pkg::UNIT_53;
			end
			x87r_pkg::PC_24: begin
				lost_any   = (item_s1.sig[39:0] != '0) || (item_s1.ext != '0);
				above_half = (item_s1.sig[39:32] > x87r_pkg::HALF_24) ||
				             ((item_s1.sig[39:32] == x87r_pkg::HALF_24) &&
				              ((item_s1.sig[31:0] != '0) || (item_s1.ext != '0)));
				at_half    = (item_s1.sig[39:32] == x87r_pkg::HALF_24) &&
				             (item_s1.sig[31:0] == '0) && (item_s1.ext == '0);
				lsb_odd    = item_s1.sig[40];
				keep_mask  = x87r_pkg::KEEP_24;
				unit       = x87r_pkg::UNIT_24;
			end
			default: begin
				lost_any   = item_s1.ext != '0;
				above_half = item_s1.ext > x87r_pkg::HALF_EXT;
				at_half    = item_s1.ext == x87r_pkg::HALF_EXT;
				lsb_odd    = item_s1.sig[0];
				keep_mask  = x87r_pkg::KEEP_64;
				unit       = x87r_pkg::UNIT_64;
			end
		endcase

		case (rnd_q)
			x87r_pkg::RND_NEAREST: want_up = above_half || (at_half && lsb_odd);
			x87r_pkg::RND_DOWN:    want_up = item_s1.neg;
			x87r_pkg::RND_UP:      want_up = !item_s1.neg;
			default:               want_up = 1'b0;
		endcase

		sum = {1'b0, item_s1.sig & keep_mask} + {1'b0, unit};

		s2_d.sig    = item_s1.sig;
		s2_d.exp    = item_s1.exp;
		s2_d.neg    = item_s1.neg;
		s2_d.denorm = item_s1.denorm;
		s2_d.lost   = x87r_pkg::LOST_NONE;
		if (lost_any) begin
			if (want_up) begin
				s2_d.lost = x87r_pkg::LOST_UP;
				// carry out renormalises to the top bit and bumps the exponent
				if (sum[64]) begin
					s2_d.sig = x87r_pkg::TOP_BIT;
					s2_d.exp = item_s1.exp + 17'sd1;
				end else begin
					s2_d.sig = sum[63:0];
				end
			end else begin
				s2_d.lost = x87r_pkg::LOST_DN;
				s2_d.sig  = item_s1.sig & keep_mask;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (adv2) begin
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v1_s1) begin
			item_s2 <= s2_d;
		end
	end

	// Stage 3: tiny handling, flags and biased exponent
	x87r_pkg::exp_t  e_fin, e_biased;
	x87r_pkg::lost_t lost_fin;
	x87r_pkg::tag_t  tag_fin;
	logic            ufl_fin, dn_fin, ovf_fin;
	logic [14:0]     eout_fin;

	always_comb begin
		e_fin    = item_s2.exp;
		lost_fin = item_s2.lost;
		tag_fin  = x87r_pkg::TAG_NORMAL;
		ufl_fin  = 1'b0;
		dn_fin   = 1'b0;
		case (item_s2.denorm)
			x87r_pkg::DN_UNMASKED: begin
				if (item_s2.exp <= x87r_pkg::EXP_TINY) begin
					e_fin   = item_s2.exp + x87r_pkg::UNMASKED_ADJUST;
					ufl_fin = 1'b1;
				end
			end
			x87r_pkg::DN_MASKED: begin
				if (item_s2.sig == '0) begin
					// rounded away to zero
					dn_fin   = 1'b1;
					ufl_fin  = 1'b1;
					e_fin    = x87r_pkg::EXP_TINY;
					tag_fin  = x87r_pkg::TAG_NIL;
					lost_fin = x87r_pkg::LOST_NONE;
				end else if (!item_s2.sig[63]) begin
					e_fin   = item_s2.exp - 17'sd1;
					ufl_fin = item_s2.lost != x87r_pkg::LOST_NONE;
					tag_fin = x87r_pkg::TAG_DENORMAL;
				end
			end
			default: ;
		endcase

		ovf_fin  = e_fin >= x87r_pkg::EXP_LIMIT;
		e_biased = e_fin + x87r_pkg::EXP_BIAS;
		eout_fin = ovf_fin ? x87r_pkg::EXP_SAT : e_biased[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
		end else if (adv3) begin
			v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v2_s2) begin
			significand_out <= item_s2.sig;
			exponent_out    <= eout_fin;
			sign_out        <= item_s2.neg;
			result_tag      <= tag_fin;
			rounded_up      <= lost_fin == x87r_pkg::LOST_UP;
			rounded_down    <= dn_fin || (lost_fin == x87r_pkg::LOST_DN);
			underflow_flag  <= ufl_fin;
			overflow_flag   <= ovf_fin;
		end
	end

	assign result_valid = v3_s3;

endmodule

`default_nettype wire

// ----- hdl/x87r_port_checker.sv -----
// Port-level checks for the x87 rounding core, bound to its top level.
// Depends on x87r_pkg (result tag codes).
`default_nettype none

module x87r_port_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        operand_stall,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [63:0] significand_out,
	input wire logic [14:0] exponent_out,
	input wire logic [1:0]  result_tag,
	input wire logic        rounded_up,
	input wire logic        rounded_down
);

	// Hold a stalled item
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result item dropped while stalled");

	// Never push back on the source while the output is empty
	a_no_spurious_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !operand_stall)
		else $error("operand stalled with empty output");

	// Round in one direction at most
	a_round_dir: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(rounded_up && rounded_down))
		else $error("rounded both up and down");

	// A zero result carries a zero significand and exponent and counts as truncated
	a_zero_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_tag == x87r_pkg::TAG_NIL) |->
			(significand_out == '0) && (exponent_out == '0) && rounded_down)
		else $error("malformed zero result");

	// Only defined tag codes appear
	a_tag_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_tag == x87r_pkg::TAG_NORMAL) ||
			(result_tag == x87r_pkg::TAG_NIL) || (result_tag == x87r_pkg::TAG_DENORMAL))
		else $error("undefined result tag");

endmodule

bind x87_extended_round_core x87r_port_checker u_port_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.operand_stall   (operand_stall),
	.result_valid    (result_valid),
	.result_stall    (result_stall),
	.significand_out (significand_out),
	.exponent_out    (exponent_out),
	.result_tag      (result_tag),
	.rounded_up      (rounded_up),
	.rounded_down    (rounded_down)
);

`default_nettype wire

// ----- verif/tb_x87_extended_round_core.sv -----
// Self-checking bench for x87_extended_round_core: directed probe table, then random items.
// Results are checked against a pinned row or in-bench predictor under several idling mixes.
// Depends on x87r_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_x87_extended_round_core;

	// Expected content of one result item
	typedef struct packed {
		logic [63:0]    sig;
		logic [14:0]    expo;
		logic           neg;
		x87r_pkg::tag_t tag;
		logic           rnd_up;
		logic           rnd_dn;
		logic           ufl;
		logic           ovf;
	} rounded_t;

	// One row of the directed table: settings, operand and, where pinned, the result
	typedef struct {
		x87r_pkg::prec_t pc;
		x87r_pkg::rnd_t  rm;
		logic            ufm;
		logic [63:0]     sig;
		logic [31:0]     ext;
		logic [15:0]     expo;
		logic            neg;
		logic            pinned;
		rounded_t        want;
	} probe_t;

	localparam rounded_t NO_WANT = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        operand_valid = 1'b0;
	logic        operand_stall;
	logic [63:0] significand_in = '0;
	logic [31:0] extension_in = '0;
	logic [15:0] exponent_in = '0;
	logic        sign_in = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [63:0] significand_out;
	logic [14:0] exponent_out;
	logic        sign_out;
	logic [1:0]  result_tag;
	logic        rounded_up;
	logic        rounded_down;
	logic        underflow_flag;
	logic        overflow_flag;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [1:0]  cfg_data = '0;

	// Shadow of the configuration registers, at their reset values
	x87r_pkg::prec_t pc_q = x87r_pkg::PC_64;
	x87r_pkg::rnd_t  rm_q = x87r_pkg::RND_NEAREST;
	logic            ufm_q = 1'b1;

	rounded_t    rounded_q [$];
	int          failures = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	logic        pin_valid = 1'b0;
	rounded_t    pin_want = '0;

	// Extremes, every mode and precision, and the tiny-value corner cases
	probe_t probes [24] = '{
		// reset settings: plain normal value, exact
		'{x87r_pkg::PC_64, x87r_pkg::RND_NEAREST, 1'b1,
			64'h8000_0000_0000_0000, 32'h0, 16'h0000, 1'b0,
			1'b1, '{64'h8000_0000_0000_0000, 15'h3fff, 1'b0, x87r_pkg::TAG_NORMAL,
				1'b0, 1'b0, 1'b0, 1'b0}},
		// all ones at the top exponent: carry out, overflow
		'{x87r_pkg::PC_64, x87r_pkg::RND_NEAREST, 1'b1,
			64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 16'h7fff, 1'b1,
			1'b1, '{64'h8000_0000_0000_0000, 15'h7fff, 1'b1, x87r_pkg::TAG_NORMAL,
				1'b1, 1'b0, 1'b0, 1'b1}},
		// lowest exponent: shifted out entirely, rounds to zero
		'{x87r_pkg::PC_64, x87r_pkg::RND_NEAREST, 1'b1,
			64'hffff_ffff_ffff_ffff, 32'h0, 16'h8000, 1'b0,
			1'b1, '{64'h0, 15'h0000, 1'b0, x87r_pkg::TAG_NIL,
				1'b0, 1'b1, 1'b1, 1'b0}},
		// exact zero with a normal exponent
		'{x87r_pkg::PC_64, x87r_pkg::RND_NEAREST, 1'b1,
			64'h0, 32'h0, 16'h0000, 1'b1,
			1'b1, '{64'h0, 15'h3fff, 1'b1, x87r_pkg::TAG_NORMAL,
				1'b0, 1'b0, 1'b0, 1'b0}},
		// ties at half an ulp, odd then even
		'{x87r_pkg::PC_64, x87r_pkg::RND_NEAREST, 1'b1,
			64'h8000_0000_0000_0001, 32'h8000_0000, 16'h0010, 1'b0,
			1'b0, NO_WANT},
		'{x87r_pkg::PC_64, x87r_pkg::RND_NEAREST, 1'b1,
			64'h8000_0000_0000_0002, 32'h8000_0000, 16'hfff0, 1'b1,
			1'b0, NO_WANT},
		// denormalise by 64, 40, 32, 1 and 65 places
		'{x87r_pkg::PC_64, x87r_pkg::RND_NEAREST, 1'b1,
			64'hc000_0000_0000_0001, 32'h0, 16'hbfc2, 1'b0,
			1'b0, NO_WANT},
		'{x87r_pkg::PC_64, x87r_pkg::RND_NEAREST, 1'b1,
			64'hffff_0000_1234_5678, 32'h0, 16'hbfda, 1'b0,
			1'b0, NO_WANT},
		'{x87r_pkg::PC_64, x87r_pkg::RND_NEAREST, 1'b1,
			64'h8765_4321_0000_0000, 32'h1, 16'hbfe2, 1'b1,
			1'b0, NO_WANT},
		'{x87r_pkg::PC_64, x87r_pkg::RND_NEAREST, 1'b1,
			64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 16'hc001, 1'b0,
			1'b0, NO_WANT},
		'{x87r_pkg::PC_64, x87r_pkg::RND_NEAREST, 1'b1,
			64'h0, 32'h0, 16'hbfc1, 1'b0,
			1'b0, NO_WANT},
		// single precision, toward minus infinity
		'{x87r_pkg::PC_24, x87r_pkg::RND_DOWN, 1'b1,
			64'hffff_ffff_ffff_ffff, 32'h0, 16'h7fff, 1'b1,
			1'b0, NO_WANT},
		'{x87r_pkg::PC_24, x87r_pkg::RND_DOWN, 1'b1,
			64'hffff_ffff_ffff_ffff, 32'h0, 16'h7fff, 1'b0,
			1'b0, NO_WANT},
		'{x87r_pkg::PC_24, x87r_pkg::RND_DOWN, 1'b1,
			64'h8000_0000_0000_0000, 32'h0, 16'hbff0, 1'b1,
			1'b0, NO_WANT},
		// double precision, toward plus infinity, underflow unmasked
		'{x87r_pkg::PC_53, x87r_pkg::RND_UP, 1'b0,
			64'h8000_0000_0000_0000, 32'h0, 16'h8000, 1'b0,
			1'b0, NO_WANT},
		'{x87r_pkg::PC_53, x87r_pkg::RND_UP, 1'b0,
			64'h8000_0000_0000_0400, 32'h1, 16'hc001, 1'b0,
			1'b0, NO_WANT},
		'{x87r_pkg::PC_53, x87r_pkg::RND_UP, 1'b0,
			64'hffff_ffff_ffff_ffff, 32'h1, 16'hc000, 1'b0,
			1'b0, NO_WANT},
		'{x87r_pkg::PC_53, x87r_pkg::RND_UP, 1'b0,
			64'hffff_ffff_ffff_ffff, 32'h0, 16'h0000, 1'b1,
			1'b0, NO_WANT},
		// reserved precision, chop
		'{x87r_pkg::PC_RSVD, x87r_pkg::RND_CHOP, 1'b1,
			64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 16'h0000, 1'b0,
			1'b0, NO_WANT},
		'{x87r_pkg::PC_RSVD, x87r_pkg::RND_CHOP, 1'b1,
			64'h1, 32'h0, 16'hc001, 1'b0,
			1'b0, NO_WANT},
		// double precision ties and just above half
		'{x87r_pkg::PC_53, x87r_pkg::RND_NEAREST, 1'b1,
			64'h8000_0000_0000_0c00, 32'h0, 16'h0000, 1'b0,
			1'b0, NO_WANT},
		'{x87r_pkg::PC_53, x87r_pkg::RND_NEAREST, 1'b1,
			64'h8000_0000_0000_0400, 32'h1, 16'h0000, 1'b1,
			1'b0, NO_WANT},
		// single precision tie, even
		'{x87r_pkg::PC_24, x87r_pkg::RND_NEAREST, 1'b0,
			64'h8000_0080_0000_0000, 32'h0, 16'h0000, 1'b0,
			1'b0, NO_WANT},
		// zero pushed up to the smallest denormal
		'{x87r_pkg::PC_64, x87r_pkg::RND_UP, 1'b1,
			64'h0, 32'h0, 16'h8000, 1'b0,
			1'b1, '{64'h1, 15'h0000, 1'b0, x87r_pkg::TAG_DENORMAL,
				1'b1, 1'b0, 1'b1, 1'b0}}
	};

	x87_extended_round_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.operand_valid  (operand_valid),
		.operand_stall  (operand_stall),
		.significand_in (significand_in),
		.extension_in   (extension_in),
		.exponent_in    (exponent_in),
		.sign_in        (sign_in),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.significand_out(significand_out),
		.exponent_out   (exponent_out),
		.sign_out       (sign_out),
		.result_tag     (result_tag),
		.rounded_up     (rounded_up),
		.rounded_down   (rounded_down),
		.underflow_flag (underflow_flag),
		.overflow_flag  (overflow_flag),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #1 clk = ~clk;

	// Predict the rounded result of one operand under the given settings
	function automatic rounded_t round_value(x87r_pkg::prec_t pc, x87r_pkg::rnd_t rm,
			logic ufm, logic [63:0] sig_in, logic [31:0] ext_in, logic [15:0] exp_in,
			logic neg);
		logic [63:0]       sig;
		logic [63:0]       keep;
		logic [63:0]       unit;
		logic [63:0]       w;
		logic [31:0]       ext;
		logic              sticky;
		logic              inexact;
		logic              odd;
		logic              bump;
		int                e;
		int                shift;
		int                half_cmp;
		x87r_pkg::denorm_t dkind;
		x87r_pkg::lost_t   lost;
		rounded_t          r;

		sig = sig_in;
		ext = ext_in;
		e = int'($signed(exp_in));
		dkind = x87r_pkg::DN_NONE;
		lost = x87r_pkg::LOST_NONE;
		r = '0;

		// denormalise tiny values when underflow is masked; fold lost bits into a sticky
		if (e <= -16383) begin
			if (ufm) begin
				shift = -16382 - e;
				dkind = x87r_pkg::DN_MASKED;
				e = -16382;
				sticky = (ext != 0) || (sig[31:0] != 0);
				if (shift > 64) begin
					ext = 32'd1;
					sig = '0;
				end else if (shift == 64) begin
					ext = sig[63:32] | 32'(sticky);
					sig = '0;
				end else if (shift > 32) begin
					ext = 32'(sig >> (shift - 32)) | 32'(sticky);
					sig = sig >> shift;
				end else if (shift == 32) begin
					ext = sig[31:0] | 32'(ext != 0);
					sig = sig >> 32;
				end else begin
					w = {sig[31:0], ext};
					ext = 32'(w >> shift) | 32'(ext != 0);
					sig = sig >> shift;
				end
			end else begin
				dkind = x87r_pkg::DN_UNMASKED;
			end
		end

		// locate the rounding point and compare the dropped part with half an ulp
		case (pc)
			x87r_pkg::PC_53: begin
				keep = 64'hffff_ffff_ffff_f800;
				unit = 64'h800;
				inexact = (ext != 0) || (sig[10:0] != 0);
				half_cmp = (sig[10:0] > 11'h400) ? 1 :
					((sig[10:0] < 11'h400) ? -1 : int'(ext != 0));
				odd = sig[11];
			end
			x87r_pkg::PC_24: begin
				keep = 64'hffff_ff00_0000_0000;
				unit = 64'h100_0000_0000;
				inexact = (sig[39:0] != 0) || (ext != 0);
				half_cmp = (sig[39:32] > 8'h80) ? 1 :
					((sig[39:32] < 8'h80) ? -1 : int'((sig[31:0] != 0) || (ext != 0)));
				odd = sig[40];
			end
			default: begin
				keep = '1;
				unit = 64'd1;
				inexact = (ext != 0);
				half_cmp = (ext > 32'h8000_0000) ? 1 : ((ext < 32'h8000_0000) ? -1 : 0);
				odd = sig[0];
			end
		endcase

		case (rm)
			x87r_pkg::RND_NEAREST: bump = (half_cmp > 0) || (half_cmp == 0 && odd);
			x87r_pkg::RND_DOWN:    bump = neg;
			x87r_pkg::RND_UP:      bump = !neg;
			default:               bump = 1'b0;
		endcase

		// round; a carry out of the top bit renormalises
		if (inexact) begin
			if (bump) begin
				sig = (sig & keep) + unit;
				if (sig == 0) begin
					sig = 64'h8000_0000_0000_0000;
					e++;
				end
				lost = x87r_pkg::LOST_UP;
			end else begin
				sig = sig & keep;
				lost = x87r_pkg::LOST_DN;
			end
		end

		// underflow handling after rounding
		if (dkind == x87r_pkg::DN_UNMASKED) begin
			if (e <= -16383) begin
				e += 24576;
				r.ufl = 1'b1;
			end
		end else if (dkind == x87r_pkg::DN_MASKED) begin
			if (sig == 0) begin
				r.rnd_dn = 1'b1;
				r.ufl = 1'b1;
				e = -16383;
				r.tag = x87r_pkg::TAG_NIL;
				lost = x87r_pkg::LOST_NONE;
			end else if (!sig[63]) begin
				e--;
				if (lost != x87r_pkg::LOST_NONE)
					r.ufl = 1'b1;
				r.tag = x87r_pkg::TAG_DENORMAL;
			end
		end

		if (lost == x87r_pkg::LOST_UP)
			r.rnd_up = 1'b1;
		else if (lost == x87r_pkg::LOST_DN)
			r.rnd_dn = 1'b1;

		// bias the exponent, saturate on overflow
		if (e >= 16384) begin
			r.ovf = 1'b1;
			r.expo = 15'h7fff;
		end else begin
			r.expo = 15'(e + 16383);
		end
		r.sig = sig;
		r.neg = neg;
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endfunction

	// Check each result item against the oldest prediction, then queue the new one
	always @(posedge clk) begin
		rounded_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (rounded_q.size() == 0) begin
					$error("result item with no prediction waiting");
					failures++;
				end else begin
					want = rounded_q.pop_front();
					check_field("significand_out", want.sig, significand_out);
					check_field("exponent_out", 64'(want.expo), 64'(exponent_out));
					check_field("sign_out", 64'(want.neg), 64'(sign_out));
					check_field("result_tag", 64'(want.tag), 64'(result_tag));
					check_field("rounded_up", 64'(want.rnd_up), 64'(rounded_up));
					check_field("rounded_down", 64'(want.rnd_dn), 64'(rounded_down));
					check_field("underflow_flag", 64'(want.ufl), 64'(underflow_flag));
					check_field("overflow_flag", 64'(want.ovf), 64'(overflow_flag));
				end
			end
			if (operand_valid && !operand_stall)
				rounded_q.push_back(pin_valid ? pin_want :
					round_value(pc_q, rm_q, ufm_q, significand_in, extension_in,
						exponent_in, sign_in));
		end
	end

	// Stall the result channel at random
	always @(negedge clk)
		result_stall <= ($urandom_range(0, 99) < stall_pct);

	// Offer one operand item, with random idle cycles ahead of it, and hold it until taken
	task automatic send_operand(logic [63:0] s, logic [31:0] x, logic [15:0] ex, logic ng,
			logic pinned, rounded_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			operand_valid <= 1'b0;
			@(negedge clk);
		end
		pin_valid = pinned;
		pin_want = want;
		operand_valid <= 1'b1;
		significand_in <= s;
		extension_in <= x;
		exponent_in <= ex;
		sign_in <= ng;
		do
			@(posedge clk);
		while (operand_stall);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (rounded_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(x87r_pkg::cfg_idx_t idx, logic [1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
	endtask

	// Drain the core, then write all three registers and track them
	task automatic apply_config(x87r_pkg::prec_t p, x87r_pkg::rnd_t r, logic m);
		operand_valid <= 1'b0;
		wait_drained();
		write_reg(x87r_pkg::CFG_PRECISION, 2'(p));
		write_reg(x87r_pkg::CFG_ROUNDING, 2'(r));
		write_reg(x87r_pkg::CFG_UFL_MASK, {1'b0, m});
		cfg_we <= 1'b0;
		pc_q = p;
		rm_q = r;
		ufm_q = m;
	endtask

	// Random operand, biased toward rounding points, tiny and huge exponents
	task automatic make_operand(output logic [63:0] s, output logic [31:0] x,
			output logic [15:0] ex, output logic ng);
		int v;
		s = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: s = '1;
			1: s = '0;
			2: s[10:0] = $urandom_range(0, 1) ? 11'h400 : 11'h7ff;
			3: s[39:0] = $urandom_range(0, 1) ? 40'h80_0000_0000 : 40'hff_ffff_ffff;
			4: s[63] = 1'b0;
			default: s[63] = 1'b1;
		endcase
		case ($urandom_range(0, 5))
			0: x = '0;
			1: x = 32'h8000_0000;
			2: x = $urandom_range(0, 3);
			default: x = $urandom;
		endcase
		case ($urandom_range(0, 7))
			0: v = int'($urandom & 32'hffff);
			1: v = 16378 + $urandom_range(0, 10);
			2: v = 32760 + $urandom_range(0, 7);
			3, 4: v = -16450 + $urandom_range(0, 75);
			5: v = -32768 + $urandom_range(0, 10);
			default: v = $urandom_range(0, 400) - 200;
		endcase
		ex = 16'(v);
		ng = 1'($urandom_range(0, 1));
	endtask

	initial begin
		logic [63:0] s;
		logic [31:0] x;
		logic [15:0] ex;
		logic        ng;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table, no idling
		foreach (probes[i]) begin
			if (probes[i].pc != pc_q || probes[i].rm != rm_q || probes[i].ufm != ufm_q)
				apply_config(probes[i].pc, probes[i].rm, probes[i].ufm);
			send_operand(probes[i].sig, probes[i].ext, probes[i].expo, probes[i].neg,
				probes[i].pinned, probes[i].want);
		end

		// random phases: cycle through idling mixes, extreme settings first
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 51; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 51; end
				default: begin send_idle_pct = 29; stall_pct = 29; end
			endcase
			case (phase)
				0: apply_config(x87r_pkg::PC_24, x87r_pkg::RND_NEAREST, 1'b0);
				1: apply_config(x87r_pkg::PC_53, x87r_pkg::RND_DOWN, 1'b1);
				2: apply_config(x87r_pkg::PC_64, x87r_pkg::RND_UP, 1'b0);
				3: apply_config(x87r_pkg::PC_RSVD, x87r_pkg::RND_CHOP, 1'b1);
				default: apply_config(x87r_pkg::prec_t'($urandom_range(0, 3)),
					x87r_pkg::rnd_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
			endcase
			repeat (156) begin
				make_operand(s, x, ex, ng);
				send_operand(s, x, ex, ng, 1'b0, NO_WANT);
			end
		end

		operand_valid <= 1'b0;
		wait_drained();
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#400_000;
		$error("timeout waiting for the core");
		$display("CHECK FAILED");
		$finish;
	end

endmodule
